/* hw/rtl/fct_pkg.sv */
// shared types and constants for the frustum cull test core
`default_nettype none

package fct_pkg;

    localparam int PLANE_COUNT  = 6;
    localparam int COORD_W      = 16;
    localparam int RADIUS_W     = 15;
    localparam int PLANE_W      = 64;
    localparam int PROD_W       = 2 * COORD_W;
    // three products plus scaled offset fit in 34 signed bits
    localparam int DIST_W       = PROD_W + 2;
    localparam int OFFSET_SHIFT = 14;
    localparam int S_TDATA_W    = 112;
    localparam int M_TDATA_W    = 8;

    localparam logic KIND_SPHERE = 1'b0;
    localparam logic KIND_BOX    = 1'b1;

    typedef struct packed {
        logic                        kind;
        logic signed [COORD_W-1:0]   a_x;
        logic signed [COORD_W-1:0]   a_y;
        logic signed [COORD_W-1:0]   a_z;
        logic signed [COORD_W-1:0]   b_x;
        logic signed [COORD_W-1:0]   b_y;
        logic signed [COORD_W-1:0]   b_z;
        logic        [RADIUS_W-1:0]  sphere_radius;
    } item_t;

endpackage

`default_nettype wire

/* hw/rtl/fct_cell.sv */
// one plane cell: holds a plane, tests the passing volume against it
`default_nettype none

module fct_cell (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        advance,
    input  wire logic                        plane_we,
    input  wire logic [fct_pkg::PLANE_W-1:0] plane_wdata,
    input  wire logic                        in_valid,
    input  wire fct_pkg::item_t              in_item,
    input  wire logic                        in_inside,
    output logic                             out_valid,
    output fct_pkg::item_t                   out_item,
    output logic                             out_inside
);
    import fct_pkg::*;

    logic [PLANE_W-1:0] plane_reg;

    logic signed [COORD_W-1:0] nx, ny, nz, off_d;
    logic signed [COORD_W-1:0] px, py, pz;
    logic                      take_bx, take_by, take_bz;

    logic                      s1_valid_reg;
    item_t                     s1_item_reg;
    logic                      s1_inside_reg;
    logic signed [PROD_W-1:0]  prod_x_reg, prod_y_reg, prod_z_reg;

    logic signed [DIST_W-1:0]  plane_dist;
    logic signed [DIST_W-1:0]  limit;
    logic                      rejected;

    logic                      out_valid_reg;
    item_t                     out_item_reg;
    logic                      out_inside_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_reg <= '0;
        end else if (plane_we) begin
            plane_reg <= plane_wdata;
        end
    end

    assign nx    = $signed(plane_reg[15:0]);
    assign ny    = $signed(plane_reg[31:16]);
    assign nz    = $signed(plane_reg[47:32]);
    assign off_d = $signed(plane_reg[63:48]);

    // box corner: min where normal is positive, max otherwise
    assign take_bx = (in_item.kind == KIND_BOX) && !(nx > 0);
    assign take_by = (in_item.kind == KIND_BOX) && !(ny > 0);
    assign take_bz = (in_item.kind == KIND_BOX) && !(nz > 0);
    assign px = take_bx ? in_item.b_x : in_item.a_x;
    assign py = take_by ? in_item.b_y : in_item.a_y;
    assign pz = take_bz ? in_item.b_z : in_item.a_z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_item_reg   <= in_item;
            s1_inside_reg <= in_inside;
            prod_x_reg    <= nx * px;
            prod_y_reg    <= ny * py;
            prod_z_reg    <= nz * pz;
        end
    end

    always_comb begin
        plane_dist = DIST_W'(prod_x_reg) + DIST_W'(prod_y_reg) + DIST_W'(prod_z_reg)
                   + (DIST_W'(off_d) <<< OFFSET_SHIFT);
        if (s1_item_reg.kind == KIND_BOX) begin
            limit = '0;
        end else begin
            limit = $signed({{(DIST_W-RADIUS_W-OFFSET_SHIFT){1'b0}},
                             s1_item_reg.sphere_radius, {OFFSET_SHIFT{1'b0}}});
        end
        rejected = plane_dist > limit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg   <= s1_item_reg;
            out_inside_reg <= s1_inside_reg && !rejected;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_item   = out_item_reg;
    assign out_inside = out_inside_reg;

    // a volume rejected upstream never comes back inside
    a_cull_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !s1_inside_reg |=> !out_inside_reg)
        else $error("culled volume became inside");

    // stalled pipeline keeps its words
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(out_valid_reg) && $stable(s1_valid_reg))
        else $error("valid changed during stall");

    // a word in the first stage moves to the output stage on the next advance
    a_two_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && s1_valid_reg |=> out_valid_reg)
        else $error("word lost between cell stages");

endmodule

`default_nettype wire

/* hw/rtl/frustum_cull_test_core.sv */
// frustum cull test core: chain of plane cells on a stream of volumes
//
// The slave stream carries one bounding volume per word: s_tuser is the
// kind (sphere or box), s_tdata the corners and radius. For every accepted
// word exactly one master word comes out, in order, whose bit 0 is 1 when
// no frustum plane rejects the volume. Planes are loaded through the write
// port (cfg_we, cfg_index, cfg_wdata); indexes beyond the last plane are
// dropped. Planes must only be changed while the stream is empty.
// Each plane lives in its own cell; a cell multiplies in one stage and
// sums and compares in the next, so a word passes both stage registers
// of every cell between acceptance and m_tvalid. One word per cycle is
// accepted back to back while the chain advances. When an output word
// waits with m_tready low the whole chain holds and s_tready drops; nothing is lost.
// Reset clears all planes to zero (every volume reads as inside) and
// empties the chain.
`default_nettype none

module frustum_cull_test_core #(
    parameter int NUM_PLANES = fct_pkg::PLANE_COUNT,
    localparam int CFG_IDX_W = $clog2(NUM_PLANES + 1)
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // config write port
    input  wire logic                          cfg_we,
    input  wire logic [CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [fct_pkg::PLANE_W-1:0]   cfg_wdata,
    // volume stream in
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, sphere_radius, one pad bit
    input  wire logic [fct_pkg::S_TDATA_W-1:0] s_tdata,
    // kind
    input  wire logic                          s_tuser,
    // result stream out
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // inside_res, seven pad bits
    output logic [fct_pkg::M_TDATA_W-1:0]      m_tdata
);
    import fct_pkg::*;

    logic  advance;
    item_t in_item;

    logic  valid_chain  [NUM_PLANES+1];
    item_t item_chain   [NUM_PLANES+1];
    logic  inside_chain [NUM_PLANES+1];

    assign advance = !m_tvalid || m_tready;
    assign s_tready = advance;

    always_comb begin
        in_item.kind          = s_tuser;
        in_item.a_x           = $signed(s_tdata[15:0]);
        in_item.a_y           = $signed(s_tdata[31:16]);
        in_item.a_z           = $signed(s_tdata[47:32]);
        in_item.b_x           = $signed(s_tdata[63:48]);
        in_item.b_y           = $signed(s_tdata[79:64]);
        in_item.b_z           = $signed(s_tdata[95:80]);
        in_item.sphere_radius = s_tdata[110:96];
    end

    assign valid_chain[0]  = s_tvalid;
    assign item_chain[0]   = in_item;
    assign inside_chain[0] = 1'b1;

    for (genvar i = 0; i < NUM_PLANES; i++) begin : g_cell
        fct_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .advance     (advance),
            .plane_we    (cfg_we && (cfg_index == CFG_IDX_W'(i))),
            .plane_wdata (cfg_wdata),
            .in_valid    (valid_chain[i]),
            .in_item     (item_chain[i]),
            .in_inside   (inside_chain[i]),
            .out_valid   (valid_chain[i+1]),
            .out_item    (item_chain[i+1]),
            .out_inside  (inside_chain[i+1])
        );
    end

    assign m_tvalid = valid_chain[NUM_PLANES];
    assign m_tdata  = {{(M_TDATA_W-1){1'b0}}, inside_chain[NUM_PLANES]};

endmodule

`default_nettype wire
